@@ rtl/ivu_pkg.sv @@
// Shared types, codes and character helpers for the setting value unescaper.
package ivu_pkg;

    // Payload of one input item and one result item
    typedef struct packed {
        logic [7:0] raw_byte;
        logic       is_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       end_of_value;
        logic       trim_overflow;
    } t_out;

    // Scan phase codes
    typedef logic [1:0] t_scan;
    localparam t_scan SCAN_SKIP  = 2'd0;
    localparam t_scan SCAN_PARSE = 2'd1;
    localparam t_scan SCAN_IGN   = 2'd2;

    // Open quote codes
    typedef logic [1:0] t_quote;
    localparam t_quote QUOTE_NONE   = 2'd0;
    localparam t_quote QUOTE_SINGLE = 2'd1;
    localparam t_quote QUOTE_DOUBLE = 2'd2;

    // Escape phase codes
    typedef logic [2:0] t_esc;
    localparam t_esc ESC_NONE = 3'd0;
    localparam t_esc ESC_BS   = 3'd1;
    localparam t_esc ESC_OCT  = 3'd2;
    localparam t_esc ESC_HEX0 = 3'd3;
    localparam t_esc ESC_HEXD = 3'd4;

    // Digit accumulator: below 512 before a shift by 4, so 13 bits hold it
    localparam int ACC_W = 13;
    localparam logic [ACC_W-1:0] ACC_LIMIT = 13'd512;

    // Per-item step slots, run in this order
    localparam int NSLOT      = 4;
    localparam int SLOT_ESC   = 0;  // byte emitted by a finished escape
    localparam int SLOT_PLAIN = 1;  // plain byte, or flush on a closing quote
    localparam int SLOT_FIN   = 2;  // unfinished escape at end of value
    localparam int SLOT_CLOSE = 3;  // closing result

    typedef struct packed {
        logic             accept;
        logic [NSLOT-1:0] exec;
    } t_cmd;

    typedef struct packed {
        logic [NSLOT-1:0] in_en;
        logic [NSLOT-1:0] en;
        logic             step_done;
    } t_sts;

    // Characters
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_DQ   = 8'h22;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_SQ   = 8'h27;
    localparam logic [7:0] CH_BS   = 8'h5C;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LB   = 8'h62;
    localparam logic [7:0] CH_LF   = 8'h66;
    localparam logic [7:0] CH_LN   = 8'h6E;
    localparam logic [7:0] CH_LR   = 8'h72;
    localparam logic [7:0] CH_LT   = 8'h74;
    localparam logic [7:0] CH_LV   = 8'h76;

    function automatic logic is_ws(input logic [7:0] b);
        is_ws = b inside {8'h20, [8'h09:8'h0D]};
    endfunction

    function automatic logic is_oct(input logic [7:0] b);
        is_oct = b inside {[8'h30:8'h37]};
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        is_hex = b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    // Low nibble of the digit value; only meaningful when is_hex holds
    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] v;
        if (b inside {[8'h30:8'h39]}) begin
            v = b - 8'h30;
        end else if (b inside {[8'h41:8'h46]}) begin
            v = b - 8'h37;
        end else begin
            v = b - 8'h57;
        end
        hex_val = v[3:0];
    endfunction

    // Single-character escapes; anything else stands for itself
    function automatic logic [7:0] esc_char(input logic [7:0] b);
        case (b)
            CH_LA:   esc_char = 8'h07;
            CH_LB:   esc_char = 8'h08;
            CH_LF:   esc_char = 8'h0C;
            CH_LN:   esc_char = 8'h0A;
            CH_LR:   esc_char = 8'h0D;
            CH_LT:   esc_char = 8'h09;
            CH_LV:   esc_char = 8'h0B;
            default: esc_char = b;
        endcase
    endfunction

endpackage

@@ rtl/ivu_ctrl.sv @@
// Controller: walks the step slots of one item and paces input acceptance.
module ivu_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  ivu_pkg::t_sts   i_sts,
    output ivu_pkg::t_cmd   o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ESC   = 5'b00010,
        ST_PLAIN = 5'b00100,
        ST_FIN   = 5'b01000,
        ST_CLOSE = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [ivu_pkg::NSLOT-1:0] cur;
    logic [ivu_pkg::NSLOT-1:0] above;
    logic [ivu_pkg::NSLOT-1:0] rem;
    logic                      idle;
    logic                      finishing;
    logic                      last_step;
    logic                      accept;

    function automatic t_state first_slot(input logic [ivu_pkg::NSLOT-1:0] v);
        if (v[ivu_pkg::SLOT_ESC]) begin
            first_slot = ST_ESC;
        end else if (v[ivu_pkg::SLOT_PLAIN]) begin
            first_slot = ST_PLAIN;
        end else if (v[ivu_pkg::SLOT_FIN]) begin
            first_slot = ST_FIN;
        end else if (v[ivu_pkg::SLOT_CLOSE]) begin
            first_slot = ST_CLOSE;
        end else begin
            first_slot = ST_IDLE;
        end
    endfunction

    assign idle      = (r_state == ST_IDLE);
    assign cur       = r_state[ivu_pkg::NSLOT:1];
    // slots strictly after the current one
    assign above     = ~(ivu_pkg::NSLOT'(cur << 1) - ivu_pkg::NSLOT'(1));
    assign rem       = i_sts.en & above;
    assign finishing = !idle && i_sts.step_done;
    assign last_step = finishing && (rem == '0);
    assign accept    = i_in_valid && (idle || last_step);

    assign o_in_stall   = !(idle || last_step);
    assign o_cmd.accept = accept;
    assign o_cmd.exec   = cur;

    always_comb begin
        n_state = r_state;
        if (accept) begin
            n_state = first_slot(i_sts.in_en);
        end else if (finishing) begin
            n_state = first_slot(rem);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_hold_until_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) && !i_sts.step_done |=> $stable(r_state))
        else $error("step slot left before it completed");

    a_no_work_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_sts.in_en == '0) |=> (r_state == ST_IDLE))
        else $error("item without steps did not return to idle");

endmodule

@@ rtl/ivu_dpath.sv @@
// Datapath: byte decode, held-whitespace store and result register.
module ivu_dpath #(
    parameter int PEND_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ivu_pkg::t_in  i_in_data,
    input  ivu_pkg::t_cmd i_cmd,
    output ivu_pkg::t_sts o_sts,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ivu_pkg::t_out o_out_data
);

    localparam int PW = (PEND_DEPTH > 1) ? $clog2(PEND_DEPTH) : 1;
    localparam int CW = $clog2(PEND_DEPTH + 1);
    localparam int AW = ivu_pkg::ACC_W;
    localparam int NS = ivu_pkg::NSLOT;

    // Decode state
    ivu_pkg::t_scan  r_scan;
    ivu_pkg::t_quote r_quote;
    ivu_pkg::t_esc   r_esc;
    logic [AW-1:0]   r_acc;

    // Step slots of the item in progress
    logic [NS-1:0] r_en;
    logic [7:0]    r_b1, r_b2, r_b3;
    logic          r_fl2;

    // Held whitespace store
    logic [7:0]    mem [PEND_DEPTH];
    logic [PW-1:0] r_head, r_tail, n_head;
    logic [CW-1:0] r_count;
    logic [7:0]    r_rd;
    logic          r_ovf_seen;

    logic          r_ovalid;
    ivu_pkg::t_out r_out, n_out;

    // Decode outputs
    ivu_pkg::t_scan  d_scan;
    ivu_pkg::t_quote d_quote;
    ivu_pkg::t_esc   d_esc;
    logic [AW-1:0]   d_acc;
    logic [NS-1:0]   d_en;
    logic [7:0]      d_b1, d_b2, d_b3;
    logic            d_fl2;

    // Step execution
    logic       can_out, full, empty;
    logic       emit_step, op_flush, op_ws;
    logic [7:0] op_byte;
    logic       push, pop, out_load, clear, set_ovf, step_done;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(PEND_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_comb begin
        logic [7:0] b;
        logic       plain;
        logic       taken;
        b       = i_in_data.raw_byte;
        plain   = 1'b0;
        taken   = 1'b0;
        d_scan  = r_scan;
        d_quote = r_quote;
        d_esc   = r_esc;
        d_acc   = r_acc;
        d_en    = '0;
        d_b1    = '0;
        d_b2    = '0;
        d_b3    = '0;
        d_fl2   = 1'b0;

        if (d_scan == ivu_pkg::SCAN_SKIP &&
            !(ivu_pkg::is_ws(b) && b != ivu_pkg::CH_NL)) begin
            d_scan = ivu_pkg::SCAN_PARSE;
        end

        if (d_scan == ivu_pkg::SCAN_PARSE) begin
            case (r_esc)
                ivu_pkg::ESC_BS: begin
                    d_esc = ivu_pkg::ESC_NONE;
                    // backslash-newline is a line continuation
                    if (b != ivu_pkg::CH_NL) begin
                        if (ivu_pkg::is_oct(b)) begin
                            d_acc = AW'(b[2:0]);
                            d_esc = ivu_pkg::ESC_OCT;
                        end else if (b == ivu_pkg::CH_X) begin
                            d_esc = ivu_pkg::ESC_HEX0;
                        end else begin
                            d_en[ivu_pkg::SLOT_ESC] = 1'b1;
                            d_b1 = ivu_pkg::esc_char(b);
                        end
                    end
                end
                ivu_pkg::ESC_OCT: begin
                    if (r_acc < ivu_pkg::ACC_LIMIT && ivu_pkg::is_oct(b)) begin
                        d_acc = {r_acc[AW-4:0], b[2:0]};
                    end else begin
                        d_en[ivu_pkg::SLOT_ESC] = 1'b1;
                        d_b1  = r_acc[7:0];
                        d_esc = ivu_pkg::ESC_NONE;
                        d_acc = '0;
                        plain = 1'b1;
                    end
                end
                ivu_pkg::ESC_HEX0: begin
                    if (ivu_pkg::is_hex(b)) begin
                        d_acc = AW'(ivu_pkg::hex_val(b));
                        d_esc = ivu_pkg::ESC_HEXD;
                    end else begin
                        // bare \x stands for x
                        d_en[ivu_pkg::SLOT_ESC] = 1'b1;
                        d_b1  = ivu_pkg::CH_X;
                        d_esc = ivu_pkg::ESC_NONE;
                        plain = 1'b1;
                    end
                end
                ivu_pkg::ESC_HEXD: begin
                    if (r_acc < ivu_pkg::ACC_LIMIT && ivu_pkg::is_hex(b)) begin
                        d_acc = {r_acc[AW-5:0], ivu_pkg::hex_val(b)};
                    end else begin
                        d_en[ivu_pkg::SLOT_ESC] = 1'b1;
                        d_b1  = r_acc[7:0];
                        d_esc = ivu_pkg::ESC_NONE;
                        d_acc = '0;
                        plain = 1'b1;
                    end
                end
                default: begin
                    d_esc = ivu_pkg::ESC_NONE;
                    plain = 1'b1;
                end
            endcase

            if (plain) begin
                if (r_quote != ivu_pkg::QUOTE_NONE) begin
                    if (b == ((r_quote == ivu_pkg::QUOTE_SINGLE) ? ivu_pkg::CH_SQ
                                                                 : ivu_pkg::CH_DQ)) begin
                        d_quote = ivu_pkg::QUOTE_NONE;
                        d_en[ivu_pkg::SLOT_PLAIN] = 1'b1;
                        d_fl2 = 1'b1;
                        taken = 1'b1;
                    end
                end else if (b == ivu_pkg::CH_NL || b == ivu_pkg::CH_HASH) begin
                    d_scan = ivu_pkg::SCAN_IGN;
                    taken  = 1'b1;
                end else if (b == ivu_pkg::CH_SQ) begin
                    d_quote = ivu_pkg::QUOTE_SINGLE;
                    taken   = 1'b1;
                end else if (b == ivu_pkg::CH_DQ) begin
                    d_quote = ivu_pkg::QUOTE_DOUBLE;
                    taken   = 1'b1;
                end
                if (!taken) begin
                    if (b == ivu_pkg::CH_BS) begin
                        d_esc = ivu_pkg::ESC_BS;
                    end else begin
                        d_en[ivu_pkg::SLOT_PLAIN] = 1'b1;
                        d_b2 = b;
                    end
                end
            end
        end

        if (i_in_data.is_last) begin
            if (d_scan == ivu_pkg::SCAN_PARSE) begin
                case (d_esc)
                    ivu_pkg::ESC_BS: begin
                        d_en[ivu_pkg::SLOT_FIN] = 1'b1;
                        d_b3 = ivu_pkg::CH_BS;
                    end
                    ivu_pkg::ESC_OCT, ivu_pkg::ESC_HEXD: begin
                        d_en[ivu_pkg::SLOT_FIN] = 1'b1;
                        d_b3 = d_acc[7:0];
                    end
                    ivu_pkg::ESC_HEX0: begin
                        d_en[ivu_pkg::SLOT_FIN] = 1'b1;
                        d_b3 = ivu_pkg::CH_X;
                    end
                    default: begin
                        d_b3 = '0;
                    end
                endcase
            end
            d_en[ivu_pkg::SLOT_CLOSE] = 1'b1;
            d_scan  = ivu_pkg::SCAN_SKIP;
            d_quote = ivu_pkg::QUOTE_NONE;
            d_esc   = ivu_pkg::ESC_NONE;
            d_acc   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan  <= ivu_pkg::SCAN_SKIP;
            r_quote <= ivu_pkg::QUOTE_NONE;
            r_esc   <= ivu_pkg::ESC_NONE;
            r_acc   <= '0;
            r_en    <= '0;
        end else if (i_cmd.accept) begin
            r_scan  <= d_scan;
            r_quote <= d_quote;
            r_esc   <= d_esc;
            r_acc   <= d_acc;
            r_en    <= d_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_b1  <= d_b1;
            r_b2  <= d_b2;
            r_b3  <= d_b3;
            r_fl2 <= d_fl2;
        end
    end

    // Step execution against the held whitespace store
    assign can_out   = !r_ovalid || !i_out_stall;
    assign full      = (r_count == CW'(PEND_DEPTH));
    assign empty     = (r_count == '0);
    assign emit_step = i_cmd.exec[ivu_pkg::SLOT_ESC] || i_cmd.exec[ivu_pkg::SLOT_PLAIN] ||
                       i_cmd.exec[ivu_pkg::SLOT_FIN];
    assign op_byte   = i_cmd.exec[ivu_pkg::SLOT_ESC]   ? r_b1 :
                       i_cmd.exec[ivu_pkg::SLOT_PLAIN] ? r_b2 : r_b3;
    assign op_flush  = i_cmd.exec[ivu_pkg::SLOT_PLAIN] && r_fl2;
    assign op_ws     = ivu_pkg::is_ws(op_byte) && !op_flush;

    always_comb begin
        push      = 1'b0;
        pop       = 1'b0;
        out_load  = 1'b0;
        clear     = 1'b0;
        set_ovf   = 1'b0;
        step_done = 1'b0;
        n_out     = '0;
        if (i_cmd.exec[ivu_pkg::SLOT_CLOSE]) begin
            if (can_out) begin
                out_load  = 1'b1;
                n_out     = '{out_byte: 8'h00, has_byte: 1'b0, end_of_value: 1'b1,
                              trim_overflow: r_ovf_seen};
                clear     = 1'b1;
                step_done = 1'b1;
            end
        end else if (emit_step) begin
            if (op_ws) begin
                if (full) begin
                    // store full: oldest held byte goes out early
                    if (can_out) begin
                        out_load  = 1'b1;
                        n_out     = '{out_byte: r_rd, has_byte: 1'b1, end_of_value: 1'b0,
                                      trim_overflow: 1'b1};
                        pop       = 1'b1;
                        push      = 1'b1;
                        set_ovf   = 1'b1;
                        step_done = 1'b1;
                    end
                end else begin
                    push      = 1'b1;
                    step_done = 1'b1;
                end
            end else if (!empty) begin
                // drain held bytes first, one per cycle while the result register is free
                if (can_out) begin
                    out_load = 1'b1;
                    n_out    = '{out_byte: r_rd, has_byte: 1'b1, end_of_value: 1'b0,
                                 trim_overflow: 1'b0};
                    pop      = 1'b1;
                end
            end else if (op_flush) begin
                step_done = 1'b1;
            end else if (can_out) begin
                out_load  = 1'b1;
                n_out     = '{out_byte: op_byte, has_byte: 1'b1, end_of_value: 1'b0,
                              trim_overflow: 1'b0};
                step_done = 1'b1;
            end
        end
    end

    assign n_head = clear ? '0 : (pop ? ptr_inc(r_head) : r_head);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_ovf_seen <= 1'b0;
        end else if (clear) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_ovf_seen <= 1'b0;
        end else begin
            r_head <= n_head;
            if (push) begin
                r_tail <= ptr_inc(r_tail);
            end
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
            if (set_ovf) begin
                r_ovf_seen <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            mem[r_tail] <= op_byte;
        end
    end

    // Read port tracks the head; a write to that entry in the same cycle is forwarded
    always_ff @(posedge i_clk) begin
        if (push && r_tail == n_head) begin
            r_rd <= op_byte;
        end else begin
            r_rd <= mem[n_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_out_data      = r_out;
    assign o_sts.in_en     = d_en;
    assign o_sts.en        = r_en;
    assign o_sts.step_done = step_done;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(PEND_DEPTH))
        else $error("held byte count above store depth");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec[ivu_pkg::SLOT_CLOSE] && step_done |=> (r_count == '0) && !r_ovf_seen)
        else $error("store not cleared after closing result");

    a_early_commit_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && n_out.has_byte && n_out.trim_overflow |-> full)
        else $error("early commit while store not full");

endmodule

@@ rtl/ini_value_unescape.sv @@
// Top level of the setting value unescaper: controller plus datapath.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_in_data  (raw_byte, is_last)
//  out     | output    | o_out_valid / i_out_stall | o_out_data (out_byte, has_byte,
//          |           |                           |   end_of_value, trim_overflow)
//
// An item with no steps is taken every cycle while the controller is idle. Otherwise the item is
// taken, then each of its steps (escape byte, plain byte or flush, end-of-value
// escape, closing result) runs in turn; the next item is taken in the cycle the
// last step completes. Each result passes through the single result register,
// and held whitespace drains one byte per cycle, while the result register is
// free, through the one read port of the whitespace store.
// Reset is synchronous, active low; the store contents are not cleared.
// A stall on the output holds the current step until the result register frees.
module ini_value_unescape #(
    parameter int PEND_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ivu_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ivu_pkg::t_out o_out_data
);

    ivu_pkg::t_cmd cmd;
    ivu_pkg::t_sts sts;

    ivu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ivu_dpath #(
        .PEND_DEPTH (PEND_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

@@ tb/ini_value_unescape_tb.sv @@
// Self-checking testbench for the setting value unescaper, with its own decoder and scoreboard.
module ini_value_unescape_tb;

    localparam int HOLD_DEPTH   = 16;
    localparam int TOTAL_ITEMS  = 200;
    localparam int TAIL_CYCLES  = 40;
    localparam int unsigned DIGIT_CEIL = 512;
    localparam int unsigned DIGIT_MASK = 'h3FFF;

    typedef logic [7:0] t_bytes[$];

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          in_valid  = 1'b0;
    logic          in_stall;
    ivu_pkg::t_in  in_data   = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    ivu_pkg::t_out out_data;
    logic [8:0]    stall_tick = '0;
    int            burst_left = 0;
    int            sent_items = 0;

    ini_value_unescape #(.PEND_DEPTH(HOLD_DEPTH)) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // space, tab, newline, vertical tab, form feed, carriage return
    function automatic logic space_byte(input logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic octal_byte(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h37;
    endfunction

    function automatic int hex_digit(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return b - 8'h30;
        if (b >= 8'h61 && b <= 8'h66) return b - 8'h57;
        if (b >= 8'h41 && b <= 8'h46) return b - 8'h37;
        return -1;
    endfunction

    function automatic void add_byte(ref t_bytes v, input logic [7:0] b);
        v.insert(v.size(), b);
    endfunction

    class unescape_board;
        ivu_pkg::t_out   due_q[$];
        ivu_pkg::t_scan  scan;
        ivu_pkg::t_quote quote;
        ivu_pkg::t_esc   esc;
        int unsigned     acc;
        logic [7:0]      held[HOLD_DEPTH];
        int              held_n;
        bit              ovf_seen;
        int              live_bytes, values, checked, early_commits, errors;

        function new();
            reset_state();
        endfunction

        function void reset_state();
            scan     = ivu_pkg::SCAN_SKIP;
            quote    = ivu_pkg::QUOTE_NONE;
            esc      = ivu_pkg::ESC_NONE;
            acc      = 0;
            held_n   = 0;
            ovf_seen = 1'b0;
        endfunction

        function void push_result(logic [7:0] b, logic has, logic eov, logic ovf);
            ivu_pkg::t_out r;
            r.out_byte      = b;
            r.has_byte      = has;
            r.end_of_value  = eov;
            r.trim_overflow = ovf;
            due_q.insert(due_q.size(), r);
        endfunction

        function void release_held();
            for (int i = 0; i < held_n; i++) push_result(held[i], 1'b1, 1'b0, 1'b0);
            held_n = 0;
        endfunction

        // whitespace waits in the hold store until something solid follows
        function void decoded(logic [7:0] b);
            if (space_byte(b)) begin
                if (held_n >= HOLD_DEPTH) begin
                    push_result(held[0], 1'b1, 1'b0, 1'b1);
                    for (int i = 0; i < HOLD_DEPTH - 1; i++) held[i] = held[i + 1];
                    held_n   = HOLD_DEPTH - 1;
                    ovf_seen = 1'b1;
                end
                held[held_n] = b;
                held_n++;
            end else begin
                release_held();
                push_result(b, 1'b1, 1'b0, 1'b0);
            end
        endfunction

        function void plain(logic [7:0] b);
            if (quote != ivu_pkg::QUOTE_NONE) begin
                if (b == ((quote == ivu_pkg::QUOTE_SINGLE) ? ivu_pkg::CH_SQ
                                                           : ivu_pkg::CH_DQ)) begin
                    quote = ivu_pkg::QUOTE_NONE;
                    release_held();
                    return;
                end
            end else if (b == ivu_pkg::CH_NL || b == ivu_pkg::CH_HASH) begin
                scan = ivu_pkg::SCAN_IGN;
                return;
            end else if (b == ivu_pkg::CH_SQ) begin
                quote = ivu_pkg::QUOTE_SINGLE;
                return;
            end else if (b == ivu_pkg::CH_DQ) begin
                quote = ivu_pkg::QUOTE_DOUBLE;
                return;
            end
            if (b == ivu_pkg::CH_BS) esc = ivu_pkg::ESC_BS;
            else decoded(b);
        endfunction

        function void parse(logic [7:0] b);
            int h;
            h = hex_digit(b);
            case (esc)
                ivu_pkg::ESC_BS: begin
                    esc = ivu_pkg::ESC_NONE;
                    if (b == ivu_pkg::CH_NL) return;  // line continuation
                    if (octal_byte(b)) begin
                        acc = b - 8'h30;
                        esc = ivu_pkg::ESC_OCT;
                        return;
                    end
                    case (b)
                        ivu_pkg::CH_LA: decoded(8'h07);
                        ivu_pkg::CH_LB: decoded(8'h08);
                        ivu_pkg::CH_LF: decoded(8'h0C);
                        ivu_pkg::CH_LN: decoded(8'h0A);
                        ivu_pkg::CH_LR: decoded(8'h0D);
                        ivu_pkg::CH_LT: decoded(8'h09);
                        ivu_pkg::CH_LV: decoded(8'h0B);
                        ivu_pkg::CH_X:  esc = ivu_pkg::ESC_HEX0;
                        default:        decoded(b);
                    endcase
                end
                ivu_pkg::ESC_OCT: begin
                    if (acc < DIGIT_CEIL && octal_byte(b)) begin
                        acc = (acc * 8 + (b - 8'h30)) & DIGIT_MASK;
                    end else begin
                        decoded(8'(acc));
                        esc = ivu_pkg::ESC_NONE;
                        acc = 0;
                        plain(b);
                    end
                end
                ivu_pkg::ESC_HEX0: begin
                    if (h >= 0) begin
                        acc = h;
                        esc = ivu_pkg::ESC_HEXD;
                    end else begin
                        decoded(ivu_pkg::CH_X);
                        esc = ivu_pkg::ESC_NONE;
                        plain(b);
                    end
                end
                ivu_pkg::ESC_HEXD: begin
                    if (acc < DIGIT_CEIL && h >= 0) begin
                        acc = (acc * 16 + h) & DIGIT_MASK;
                    end else begin
                        decoded(8'(acc));
                        esc = ivu_pkg::ESC_NONE;
                        acc = 0;
                        plain(b);
                    end
                end
                default: plain(b);
            endcase
        endfunction

        function void note_raw(ivu_pkg::t_in it);
            if (scan != ivu_pkg::SCAN_IGN) live_bytes++;
            if (scan == ivu_pkg::SCAN_SKIP &&
                !(space_byte(it.raw_byte) && it.raw_byte != ivu_pkg::CH_NL))
                scan = ivu_pkg::SCAN_PARSE;
            if (scan == ivu_pkg::SCAN_PARSE) parse(it.raw_byte);
            if (it.is_last) begin
                if (scan == ivu_pkg::SCAN_PARSE) begin
                    case (esc)
                        ivu_pkg::ESC_BS:                    decoded(ivu_pkg::CH_BS);
                        ivu_pkg::ESC_OCT, ivu_pkg::ESC_HEXD: decoded(8'(acc));
                        ivu_pkg::ESC_HEX0:                  decoded(ivu_pkg::CH_X);
                        default:                            ;
                    endcase
                end
                // held whitespace is trailing: dropped
                push_result(8'h00, 1'b0, 1'b1, ovf_seen);
                reset_state();
                values++;
            end
        endfunction

        function void check_result(ivu_pkg::t_out got);
            ivu_pkg::t_out want;
            if (due_q.size() == 0) begin
                if (errors < 10)
                    $display("unexpected result: byte %02h has %b eov %b ovf %b",
                             got.out_byte, got.has_byte, got.end_of_value, got.trim_overflow);
                errors++;
                return;
            end
            want = due_q.pop_front();
            checked++;
            if (want.has_byte && want.trim_overflow) early_commits++;
            if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
                got.end_of_value !== want.end_of_value ||
                got.trim_overflow !== want.trim_overflow) begin
                if (errors < 10)
                    $display("mismatch at result %0d: want byte %02h has %b eov %b ovf %b, %s",
                             checked, want.out_byte, want.has_byte, want.end_of_value,
                             want.trim_overflow,
                             $sformatf("got byte %02h has %b eov %b ovf %b", got.out_byte,
                                       got.has_byte, got.end_of_value, got.trim_overflow));
                errors++;
            end
        endfunction
    endclass

    unescape_board board;

    always #5 clk = ~clk;

    // receiver stall pattern: calm, light random, periodic bursts, heavy random
    always @(negedge clk) begin
        stall_tick <= stall_tick + 1'b1;
        case (stall_tick[8:7])
            2'd0:    out_stall <= 1'b0;
            2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
            2'd2:    out_stall <= (stall_tick[2:0] < 3'd3);
            default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    // input is noted before output is checked, so ordering in a step never matters
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) board.note_raw(in_data);
            if (out_valid && !out_stall) board.check_result(out_data);
        end
    end

    task automatic send_raw(input logic [7:0] b, input logic last);
        @(negedge clk);
        in_data  <= '{raw_byte: b, is_last: last};
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        sent_items++;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_value(input t_bytes v);
        foreach (v[i]) send_raw(v[i], i == v.size() - 1);
    endtask

    task automatic send_text(input string s);
        t_bytes v;
        for (int i = 0; i < s.len(); i++) add_byte(v, s[i]);
        send_value(v);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.due_q.size() != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] space_pick(input bit with_nl);
        case ($urandom_range(0, with_nl ? 5 : 4))
            0:       return 8'h09;
            1:       return 8'h0B;
            2:       return 8'h0C;
            3:       return 8'h0D;
            5:       return ivu_pkg::CH_NL;
            default: return 8'h20;
        endcase
    endfunction

    // mostly well-formed values with random content; some noise and truncation
    function automatic t_bytes make_value();
        t_bytes     v;
        string      esc_set = "abfnrtvx\\'\"#q";
        string      hex_set = "0123456789abcdefABCDEF";
        logic [7:0] qc;
        bit         quoted;
        int         n;
        int         cut;
        quoted = 1'b0;
        qc     = ivu_pkg::CH_DQ;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) add_byte(v, 8'($urandom_range(0, 255)));
            return v;
        end
        repeat ($urandom_range(0, 3)) add_byte(v, space_pick(1'b0));
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 9))
                0, 1: repeat ($urandom_range(1, 4)) add_byte(v, 8'($urandom_range(8'h41, 8'h7A)));
                2: begin
                    n = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 22)
                                                    : $urandom_range(1, 3);
                    repeat (n) add_byte(v, space_pick(quoted));
                end
                3: begin
                    if (!quoted) qc = $urandom_range(0, 1) ? ivu_pkg::CH_SQ : ivu_pkg::CH_DQ;
                    add_byte(v, qc);
                    quoted = !quoted;
                end
                4: begin
                    add_byte(v, ivu_pkg::CH_BS);
                    add_byte(v, esc_set[$urandom_range(0, esc_set.len() - 1)]);
                end
                5: begin
                    add_byte(v, ivu_pkg::CH_BS);
                    repeat ($urandom_range(1, 5)) add_byte(v, 8'h30 + 8'($urandom_range(0, 7)));
                end
                6: begin
                    add_byte(v, ivu_pkg::CH_BS);
                    add_byte(v, ivu_pkg::CH_X);
                    repeat ($urandom_range(0, 5)) add_byte(v, hex_set[$urandom_range(0, 21)]);
                end
                7: begin
                    add_byte(v, ivu_pkg::CH_BS);
                    add_byte(v, $urandom_range(0, 1) ? ivu_pkg::CH_NL
                                                     : 8'($urandom_range(0, 255)));
                end
                8: add_byte(v, $urandom_range(0, 1) ? ivu_pkg::CH_HASH : ivu_pkg::CH_NL);
                default: add_byte(v, 8'($urandom_range(0, 255)));
            endcase
        end
        if (quoted && $urandom_range(0, 1)) add_byte(v, qc);
        repeat ($urandom_range(0, 2)) add_byte(v, space_pick(1'b0));
        if ($urandom_range(0, 7) == 0) begin
            cut = $urandom_range(1, v.size());
            v   = v[0:cut-1];
        end
        return v;
    endfunction

    initial begin
        board = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // quoted literals, hex and octal runs, escaped newline and quote, stray backslash
        send_text(" \t'#\"\n'\\x4G\\7777#");
        send_text("\\xg\\\n\\\"\\q\\");
        send_value('{8'h00, 8'hFF});
        wait_drained();

        while (sent_items < TOTAL_ITEMS) begin
            send_value(make_value());
            if ($urandom_range(0, 7) == 0) wait_drained();
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (board.due_q.size() != 0) begin
            $display("%0d expected results never arrived", board.due_q.size());
            board.errors += board.due_q.size();
        end
        $display("Covered %0d values, %0d items, %0d parsed bytes, %0d results",
                 board.values, sent_items, board.live_bytes, board.checked);
        $display("Mix: quoting, escapes, digit runs, comments, noise, truncation; %0d %s",
                 board.early_commits, "early whitespace commits");
        if (board.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ivu_pkg.sv
rtl/ivu_ctrl.sv
rtl/ivu_dpath.sv
rtl/ini_value_unescape.sv
tb/ini_value_unescape_tb.sv
